[design/assert_macros.svh]
// Concurrent assertion macros used by the detector top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr)
`endif
`endif

[design/udzd_pkg.sv]
// Types, constants and register codes for the uniform dark zone detector.
package udzd_pkg;

	localparam int SENSOR_COUNT = 8;
	localparam int SAMPLE_BITS  = 12;
	localparam int THR_W        = 12;
	localparam int RUN_W        = 8;
	localparam int CFG_W        = 12;
	localparam int REG_IDX_W    = 3;

	localparam int SUM_W  = SAMPLE_BITS + $clog2(SENSOR_COUNT);
	localparam int PROD_W = THR_W + $clog2(SENSOR_COUNT);
	localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
	localparam int SPR_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	localparam int S_TDATA_W = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = 8;

	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	localparam logic [THR_W-1:0] DARK_AVG_MIN_RST   = THR_W'(3276);
	localparam logic [THR_W-1:0] UNIF_SPREAD_RST    = THR_W'(410);
	localparam logic [THR_W-1:0] EXIT_SPREAD_RST    = THR_W'(451);
	localparam logic [THR_W-1:0] EXIT_AVG_RST       = THR_W'(3071);
	localparam logic [RUN_W-1:0] ENTER_EPOCHS_RST   = RUN_W'(3);
	localparam logic [RUN_W-1:0] EXIT_EPOCHS_RST    = RUN_W'(3);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DARK_AVERAGE_MIN   = 3'd0,
		REG_UNIFORM_SPREAD_MAX = 3'd1,
		REG_EXIT_SPREAD_LIMIT  = 3'd2,
		REG_EXIT_AVERAGE_LIMIT = 3'd3,
		REG_ENTER_EPOCHS       = 3'd4,
		REG_EXIT_EPOCHS        = 3'd5
	} reg_idx_t;

	// Check kind carried in tuser.
	localparam logic OP_ACTIVATE = 1'b0;
	localparam logic OP_EXIT     = 1'b1;

	typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] sample_vec_t;

	typedef struct packed {
		logic [SUM_W-1:0]       sum;
		logic [SAMPLE_BITS-1:0] spread;
	} stats_t;

endpackage

[design/uniform_dark_zone_detector_top.sv]
// Top level of the uniform dark zone detector: request register, checks, result register.
//
// Usage:
//   s_* carries one request per epoch: s_tdata holds sensor_0..sensor_7, 12 bits
//   each from the lowest bit up; s_tuser selects the check (0 activate, 1 exit).
//   m_* returns one result per request: m_tdata[0] zone_changed, [1] zone_active,
//   [2] uniform_dark, upper bits zero.
//   A request waits in the request register and moves into the result register,
//   which drives m_tvalid, once that is free. One request is taken every cycle
//   while m_tready stays high; the epoch statistics, threshold compares and run
//   counter update all fit between the request register and the result register.
//   When m_tready is low the result register holds; the request register still
//   takes one more request, after which s_tready drops until the result moves.
//   Reset (arst_n low) clears the zone flag, both run counters, the valid bits
//   and loads the configuration registers with their default values.
//   Configuration: wr_en writes wr_data into register wr_index;
//   write only while no request is in flight. Indexes beyond the list are ignored.
`include "assert_macros.svh"

module uniform_dark_zone_detector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sensor_0 .. sensor_7, SAMPLE_BITS each, lowest first
	input  logic [udzd_pkg::S_TDATA_W-1:0]      s_tdata,
	// operation
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// zone_changed, zone_active, uniform_dark, zero fill
	output logic [udzd_pkg::M_TDATA_W-1:0]      m_tdata,
	input  logic                                wr_en,
	input  logic [udzd_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [udzd_pkg::CFG_W-1:0]          wr_data
);

	localparam int RUN_W = udzd_pkg::RUN_W;
	localparam int THR_W = udzd_pkg::THR_W;
	localparam int CMP_W = udzd_pkg::CMP_W;
	localparam int SPR_W = udzd_pkg::SPR_W;

	// configuration
	logic [THR_W-1:0] dark_avg_min_q;
	logic [THR_W-1:0] unif_spread_max_q;
	logic [THR_W-1:0] exit_spread_lim_q;
	logic [THR_W-1:0] exit_avg_lim_q;
	logic [RUN_W-1:0] enter_epochs_q;
	logic [RUN_W-1:0] exit_epochs_q;

	// detector state
	logic             in_zone_q;
	logic [RUN_W-1:0] enter_run_q;
	logic [RUN_W-1:0] exit_run_q;

	// pipeline
	logic                          valid_s1;
	logic                          op_s1;
	udzd_pkg::sample_vec_t         samples_s1;
	logic                          m_tvalid_s2;
	logic [udzd_pkg::M_TDATA_W-1:0] m_tdata_s2;

	logic             out_free;
	logic             move_s1;
	udzd_pkg::stats_t stats;

	logic             dark;
	logic             rough;
	logic             zone_nxt;
	logic             changed_nxt;
	logic [RUN_W-1:0] enter_run_nxt;
	logic [RUN_W-1:0] exit_run_nxt;

	assign out_free = !m_tvalid_s2 || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign move_s1  = valid_s1 && out_free;
	assign m_tvalid = m_tvalid_s2;
	assign m_tdata  = m_tdata_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_avg_min_q    <= udzd_pkg::DARK_AVG_MIN_RST;
			unif_spread_max_q <= udzd_pkg::UNIF_SPREAD_RST;
			exit_spread_lim_q <= udzd_pkg::EXIT_SPREAD_RST;
			exit_avg_lim_q    <= udzd_pkg::EXIT_AVG_RST;
			enter_epochs_q    <= udzd_pkg::ENTER_EPOCHS_RST;
			exit_epochs_q     <= udzd_pkg::EXIT_EPOCHS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				udzd_pkg::REG_DARK_AVERAGE_MIN:   dark_avg_min_q    <= wr_data[THR_W-1:0];
				udzd_pkg::REG_UNIFORM_SPREAD_MAX: unif_spread_max_q <= wr_data[THR_W-1:0];
				udzd_pkg::REG_EXIT_SPREAD_LIMIT:  exit_spread_lim_q <= wr_data[THR_W-1:0];
				udzd_pkg::REG_EXIT_AVERAGE_LIMIT: exit_avg_lim_q    <= wr_data[THR_W-1:0];
				udzd_pkg::REG_ENTER_EPOCHS:       enter_epochs_q    <= wr_data[RUN_W-1:0];
				udzd_pkg::REG_EXIT_EPOCHS:        exit_epochs_q     <= wr_data[RUN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1      <= s_tuser;
			samples_s1 <= s_tdata[udzd_pkg::SENSOR_COUNT*udzd_pkg::SAMPLE_BITS-1:0];
		end
	end

	udzd_stats u_stats (
		.samples (samples_s1),
		.stats   (stats)
	);

	// Average tests compare the sum against limit times sensor count.
	always_comb begin
		logic [CMP_W-1:0] sum_x;
		logic [SPR_W-1:0] spread_x;
		sum_x    = CMP_W'(stats.sum);
		spread_x = SPR_W'(stats.spread);
		dark  = (sum_x >= CMP_W'(dark_avg_min_q) * CMP_W'(udzd_pkg::SENSOR_COUNT))
			&& (spread_x <= SPR_W'(unif_spread_max_q));
		rough = (spread_x > SPR_W'(exit_spread_lim_q))
			|| (sum_x < CMP_W'(exit_avg_lim_q) * CMP_W'(udzd_pkg::SENSOR_COUNT));
	end

	always_comb begin
		zone_nxt      = in_zone_q;
		changed_nxt   = 1'b0;
		enter_run_nxt = enter_run_q;
		exit_run_nxt  = exit_run_q;
		if (op_s1 == udzd_pkg::OP_ACTIVATE) begin
			if (dark) begin
				if (enter_run_q != udzd_pkg::RUN_MAX) enter_run_nxt = enter_run_q + RUN_W'(1);
				exit_run_nxt = '0;
			end else begin
				enter_run_nxt = '0;
			end
			if (!in_zone_q && enter_run_nxt >= enter_epochs_q) begin
				zone_nxt      = 1'b1;
				enter_run_nxt = '0;
				changed_nxt   = 1'b1;
			end
		end else begin
			if (rough) begin
				if (exit_run_q != udzd_pkg::RUN_MAX) exit_run_nxt = exit_run_q + RUN_W'(1);
			end else begin
				exit_run_nxt = '0;
			end
			if (in_zone_q && exit_run_nxt >= exit_epochs_q) begin
				zone_nxt     = 1'b0;
				exit_run_nxt = '0;
				changed_nxt  = 1'b1;
			end
		end
	end

	// advance state only when the request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_zone_q   <= 1'b0;
			enter_run_q <= '0;
			exit_run_q  <= '0;
		end else if (move_s1) begin
			in_zone_q   <= zone_nxt;
			enter_run_q <= enter_run_nxt;
			exit_run_q  <= exit_run_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_s2 <= 1'b0;
		end else if (out_free) begin
			m_tvalid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			m_tdata_s2 <= {{(udzd_pkg::M_TDATA_W-3){1'b0}}, dark, zone_nxt, changed_nxt};
		end
	end

	`ASSERT_CLK(a_zone_holds_when_idle, clk, arst_n, !move_s1 |=> $stable(in_zone_q))
	`ASSERT_CLK(a_result_matches_zone, clk, arst_n, move_s1 |=> (m_tdata_s2[1] == in_zone_q))
	`ASSERT_CLK(a_enter_clears_run, clk, arst_n, $rose(in_zone_q) |-> (enter_run_q == '0))
	`ASSERT_NEVER(a_change_without_move, clk, arst_n, !$stable(in_zone_q) && !$past(move_s1))

endmodule

[design/udzd_stats.sv]
// Sum and spread (maximum minus minimum) over one epoch of sensor readings.
module udzd_stats (
	input  udzd_pkg::sample_vec_t samples,
	output udzd_pkg::stats_t      stats
);

	always_comb begin
		logic [udzd_pkg::SUM_W-1:0]       acc;
		logic [udzd_pkg::SAMPLE_BITS-1:0] mn;
		logic [udzd_pkg::SAMPLE_BITS-1:0] mx;
		acc = '0;
		mn  = '1;
		mx  = '0;
		for (int i = 0; i < udzd_pkg::SENSOR_COUNT; i++) begin
			acc = acc + udzd_pkg::SUM_W'(samples[i]);
			if (samples[i] < mn) mn = samples[i];
			if (samples[i] > mx) mx = samples[i];
		end
		stats.sum    = acc;
		stats.spread = mx - mn;
	end

endmodule
